// File: hdl/lmcs_pkg.sv
package lmcs_pkg;

    localparam int MAX_KERNEL = 9;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int POS_W      = 10;
    localparam int DIM_W      = 11;
    localparam int K_W        = 4;
    localparam int SLOT_W     = $clog2(MAX_KERNEL);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MEM_DEPTH  = MAX_KERNEL * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] REG_KERNEL_SIZE  = 2'd0;
    localparam logic [1:0] REG_MASK_SHAPE   = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Mask shape codes.
    localparam logic [1:0] SHAPE_CIRCLE      = 2'd1;
    localparam logic [1:0] SHAPE_WIDE_CIRCLE = 2'd2;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  start_of_frame;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0]      center_row;
        logic [POS_W-1:0]      center_col;
        logic [PIXEL_BITS-1:0] stretched;
        logic                  flat_window;
        logic                  last_of_frame;
    } out_t;

    // Saturated configuration as seen by the datapath.
    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [K_W-2:0]   half;
        logic [1:0]       shape;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    // One request handed from the front end to the back end.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [ADDR_W-1:0]     wr_addr;
        logic                  emit;
        logic [SLOT_W-1:0]     top_slot;
        logic [COL_W-1:0]      left;
        logic [POS_W-1:0]      out_row;
        logic [POS_W-1:0]      out_col;
        logic                  last;
    } job_t;

endpackage

// File: hdl/lmcs_front.sv
module lmcs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lmcs_pkg::in_t     in_data,
    output logic              in_stall,
    input  lmcs_pkg::cfg_t    cfg,
    input  logic              q_full,
    output logic              push,
    output lmcs_pkg::job_t    job
);

    localparam int POS_W  = lmcs_pkg::POS_W;
    localparam int SLOT_W = lmcs_pkg::SLOT_W;

    logic [lmcs_pkg::POS_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [lmcs_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [lmcs_pkg::POS_W-1:0]  r_cur, c_cur;
    logic [lmcs_pkg::SLOT_W-1:0] s_cur;
    logic [11:0] km1, rlim, clim, r12, c12;
    logic [lmcs_pkg::DIM_W-1:0] c1, r1;
    logic [lmcs_pkg::SLOT_W+1:0] top_sum;
    logic [lmcs_pkg::POS_W-1:0] back_off;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        r_cur = in_data.start_of_frame ? '0 : row_reg;
        c_cur = in_data.start_of_frame ? '0 : col_reg;
        s_cur = in_data.start_of_frame ? '0 : slot_reg;
        km1   = 12'(cfg.k) - 12'd1;
        rlim  = 12'(cfg.height) + km1 - 12'({cfg.half, 1'b0});
        clim  = 12'(cfg.width) + km1 - 12'({cfg.half, 1'b0});
        r12   = 12'(r_cur);
        c12   = 12'(c_cur);
        back_off = POS_W'(cfg.k) - POS_W'(1) - POS_W'(cfg.half);

        top_sum = (SLOT_W+2)'(s_cur) + (SLOT_W+2)'(lmcs_pkg::MAX_KERNEL) - (SLOT_W+2)'(km1);
        if (top_sum >= (SLOT_W+2)'(lmcs_pkg::MAX_KERNEL))
        begin
            top_sum = top_sum - (SLOT_W+2)'(lmcs_pkg::MAX_KERNEL);
        end

        job.pixel    = in_data.pixel;
        job.wr_addr  = lmcs_pkg::ADDR_W'({s_cur, c_cur});
        job.emit     = (r12 >= km1) && (c12 >= km1) && (r12 < rlim) && (c12 < clim);
        job.top_slot = top_sum[lmcs_pkg::SLOT_W-1:0];
        job.left     = lmcs_pkg::COL_W'(c_cur - POS_W'(km1));
        job.out_row  = r_cur - back_off;
        job.out_col  = c_cur - back_off;
        job.last     = (r12 == rlim - 12'd1) && (c12 == clim - 12'd1);

        c1 = lmcs_pkg::DIM_W'(c_cur) + 11'd1;
        r1 = lmcs_pkg::DIM_W'(r_cur) + 11'd1;
        row_next  = r_cur;
        slot_next = s_cur;
        col_next  = c1[lmcs_pkg::POS_W-1:0];
        if (c1 >= cfg.width)
        begin
            col_next = '0;
            if (r1 >= cfg.height)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = r1[lmcs_pkg::POS_W-1:0];
                slot_next = (s_cur == SLOT_W'(lmcs_pkg::MAX_KERNEL - 1)) ? '0 : s_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (push)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

endmodule

// File: hdl/lmcs_queue.sv
module lmcs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lmcs_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output lmcs_pkg::job_t head
);

    lmcs_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: hdl/lmcs_back.sv
module lmcs_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  lmcs_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  lmcs_pkg::job_t q_head,
    output logic           pop,
    output logic           out_valid,
    output lmcs_pkg::out_t out_data,
    input  logic           out_stall
);

    typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_PREP, ST_DIV, ST_OUT} state_t;

    localparam int PB  = lmcs_pkg::PIXEL_BITS;
    localparam int K_W = lmcs_pkg::K_W;

    state_t state_reg;
    logic [PB-1:0] mem [lmcs_pkg::MEM_DEPTH];
    logic [PB-1:0] rd_data_reg;
    logic [lmcs_pkg::ADDR_W-1:0] rd_addr;

    lmcs_pkg::job_t job_reg;
    logic [lmcs_pkg::SLOT_W-1:0] rs_reg;
    logic [lmcs_pkg::COL_W-1:0]  cc_reg;
    logic [lmcs_pkg::K_W-1:0]    i_reg, j_reg, rd_i_reg, rd_j_reg;
    logic                        rd_vld_reg, any_reg;
    logic [PB-1:0] mn_reg, mx_reg, ctr_reg, den_reg, rem_reg, quo_reg;
    logic [lmcs_pkg::K_W-1:0] cnt_reg;
    logic                     flat_reg;
    logic [PB-1:0]            d;
    logic [2*PB-1:0]          num;
    logic [PB:0]              trial;
    logic [lmcs_pkg::K_W-1:0] di, dj, kl;
    logic [7:0]               dist_sq, r2;
    logic                     in_mask, full_sq;

    assign pop     = (state_reg == ST_IDLE) && q_valid;
    assign rd_addr = lmcs_pkg::ADDR_W'({rs_reg, cc_reg});
    assign kl      = cfg.k - 1'b1;

    always_comb
    begin
        di = (rd_i_reg > K_W'(cfg.half)) ? rd_i_reg - K_W'(cfg.half) : K_W'(cfg.half) - rd_i_reg;
        dj = (rd_j_reg > K_W'(cfg.half)) ? rd_j_reg - K_W'(cfg.half) : K_W'(cfg.half) - rd_j_reg;
        dist_sq = 8'(di) * 8'(di) + 8'(dj) * 8'(dj);
        r2 = (cfg.shape == lmcs_pkg::SHAPE_WIDE_CIRCLE)
           ? (8'(cfg.half) + 8'd1) * 8'(cfg.half) : 8'(cfg.half) * 8'(cfg.half);
        full_sq = ((cfg.shape != lmcs_pkg::SHAPE_CIRCLE)
                   && (cfg.shape != lmcs_pkg::SHAPE_WIDE_CIRCLE)) || !cfg.k[0];
        in_mask = full_sq || (dist_sq <= r2);
        d       = ctr_reg - mn_reg;
        num     = {d, {PB{1'b0}}} - (2*PB)'(d);
        trial   = {rem_reg, quo_reg[PB-1]};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem[q_head.wr_addr] <= q_head.pixel;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == ST_SCAN);
            if ((state_reg == ST_OUT) && (!out_valid || !out_stall))
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end

            if (rd_vld_reg)
            begin
                if ((rd_i_reg == K_W'(cfg.half)) && (rd_j_reg == K_W'(cfg.half)))
                begin
                    ctr_reg <= rd_data_reg;
                end
                if (in_mask)
                begin
                    if (!any_reg || rd_data_reg < mn_reg)
                    begin
                        mn_reg <= rd_data_reg;
                    end
                    if (!any_reg || rd_data_reg > mx_reg)
                    begin
                        mx_reg <= rd_data_reg;
                    end
                    any_reg <= 1'b1;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_head.emit)
                    begin
                        job_reg   <= q_head;
                        rs_reg    <= q_head.top_slot;
                        cc_reg    <= q_head.left;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        any_reg   <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_i_reg <= i_reg;
                    rd_j_reg <= j_reg;
                    if (j_reg == kl)
                    begin
                        j_reg  <= '0;
                        i_reg  <= i_reg + 1'b1;
                        cc_reg <= job_reg.left;
                        rs_reg <= (rs_reg == lmcs_pkg::SLOT_W'(lmcs_pkg::MAX_KERNEL - 1))
                                ? '0 : rs_reg + 1'b1;
                        if (i_reg == kl)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        j_reg  <= j_reg + 1'b1;
                        cc_reg <= cc_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    flat_reg <= (mx_reg == mn_reg);
                    den_reg  <= mx_reg - mn_reg;
                    rem_reg  <= num[2*PB-1:PB];
                    quo_reg  <= (mx_reg == mn_reg) ? '0 : num[PB-1:0];
                    cnt_reg  <= '0;
                    if (mx_reg == mn_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (trial >= {1'b0, den_reg})
                    begin
                        rem_reg <= PB'(trial - {1'b0, den_reg});
                        quo_reg <= {quo_reg[PB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[PB-1:0];
                        quo_reg <= {quo_reg[PB-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == K_W'(PB - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_data.center_row    <= job_reg.out_row;
                        out_data.center_col    <= job_reg.out_col;
                        out_data.stretched     <= quo_reg;
                        out_data.flat_window   <= flat_reg;
                        out_data.last_of_frame <= job_reg.last;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/local_minmax_contrast_stretch_core.sv
// Local min/max contrast stretch over a raster stream of unsigned 16-bit
// pixels. For every interior position of a k x k window (k from 2 to 9) the
// block returns the window's center pixel rescaled as
// floor((center - min) * 65535 / (max - min)), where min and max are taken
// over the window positions chosen by the mask shape; a flat window returns 0
// with flat_window set, and border pixels return nothing. A front end tracks
// the frame position and classifies each pixel, a two-entry queue holds the
// requests, and a back end owns the line store, scans the window and runs a
// one-bit-per-cycle divider. A pixel that produces no result is taken while
// the back end is idle, so such pixels stream at one per clock while no
// result is being computed. A pixel that produces a result holds the back end
// while it takes the request, reads the line store once per window position
// through its single read port, drains the read and sets up the divide, runs
// the 16-step divider (skipped for a flat window) and loads the output
// register, longer while the result side stalls. Meanwhile the queue fills
// and the input stalls. The line store is not cleared; window entries never
// written in the current frame read as arbitrary data. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
module local_minmax_contrast_stretch_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [10:0]    cfg_data,
    input  logic           in_valid,
    input  lmcs_pkg::in_t  in_data,
    output logic           in_stall,
    output logic           out_valid,
    output lmcs_pkg::out_t out_data,
    input  logic           out_stall
);

    logic [3:0]  kernel_size_reg;
    logic [1:0]  mask_shape_reg;
    logic [10:0] image_width_reg, image_height_reg;
    lmcs_pkg::cfg_t cfg;
    lmcs_pkg::job_t push_job, head;
    logic push, q_full, pop, q_valid;

    // Configuration registers, written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg  <= 4'd3;
            mask_shape_reg   <= 2'd0;
            image_width_reg  <= 11'd640;
            image_height_reg <= 11'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lmcs_pkg::REG_KERNEL_SIZE:  kernel_size_reg  <= cfg_data[3:0];
                lmcs_pkg::REG_MASK_SHAPE:   mask_shape_reg   <= cfg_data[1:0];
                lmcs_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                lmcs_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:                    kernel_size_reg  <= kernel_size_reg;
            endcase
        end
    end

    // Saturate the registers to the ranges the datapath supports. The center
    // offset is k/2 for both odd and even k.
    always_comb
    begin
        cfg.k = kernel_size_reg;
        if (kernel_size_reg < 4'd2)
        begin
            cfg.k = 4'd2;
        end
        else if (kernel_size_reg > 4'(lmcs_pkg::MAX_KERNEL))
        begin
            cfg.k = 4'(lmcs_pkg::MAX_KERNEL);
        end
        cfg.half  = cfg.k[3:1];
        cfg.shape = mask_shape_reg;
        cfg.width = image_width_reg;
        if (image_width_reg < 11'd2)
        begin
            cfg.width = 11'd2;
        end
        else if (image_width_reg > 11'(lmcs_pkg::MAX_WIDTH))
        begin
            cfg.width = 11'(lmcs_pkg::MAX_WIDTH);
        end
        cfg.height = image_height_reg;
        if (image_height_reg < 11'd2)
        begin
            cfg.height = 11'd2;
        end
        else if (image_height_reg > 11'(lmcs_pkg::MAX_HEIGHT))
        begin
            cfg.height = 11'(lmcs_pkg::MAX_HEIGHT);
        end
    end

    lmcs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    lmcs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head)
    );

    lmcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_head    (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

endmodule

// File: tb/lmcs_checker.sv
`default_nettype none

// Watches both request channels and the register port, predicts each result
// from its own copy of the line store and window mask, and compares every
// returned result against the oldest prediction.
module lmcs_checker
    import lmcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic in_valid,
    input  wire in_t in_data,
    input  wire logic in_stall,
    input  wire logic out_valid,
    input  wire out_t out_data,
    input  wire logic out_stall,
    output int errors,
    output int pending,
    output int results,
    output int flats
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [3:0] k_reg;
    logic [1:0] shape_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [15:0] pix_store [0:MAX_KERNEL*MAX_WIDTH-1];
    bit mask_bit [0:MAX_KERNEL-1][0:MAX_KERNEL-1];
    int row_pos;
    int col_pos;
    out_t stretch_queue [$];

    function automatic int sat(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // The circle masks only apply to odd window sizes.
    function automatic void rebuild_mask();
        int k;
        int half;
        int r2;
        int di;
        int dj;
        bit full;
        k = sat(k_reg, 2, MAX_KERNEL);
        half = k / 2;
        full = (shape_reg != SHAPE_CIRCLE && shape_reg != SHAPE_WIDE_CIRCLE) || (k % 2 == 0);
        r2 = (shape_reg == SHAPE_CIRCLE) ? half * half : (half + 1) * half;
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            for (int j = 0; j < MAX_KERNEL; j++)
            begin
                di = i - half;
                dj = j - half;
                mask_bit[i][j] = (i < k) && (j < k) && (full || di * di + dj * dj <= r2);
            end
        end
    endfunction

    // Advances the frame position by one pixel and queues the stretched
    // center value when the window sits fully inside the frame.
    function automatic void predict_pixel(in_t px);
        int k;
        int w;
        int h;
        int off;
        int rlim;
        int clim;
        int r;
        int c;
        int top;
        int left;
        int v;
        int mn;
        int mx;
        int ctr;
        bit any;
        longint quot;
        out_t res;
        k = sat(k_reg, 2, MAX_KERNEL);
        w = sat(width_reg, 2, MAX_WIDTH);
        h = sat(height_reg, 2, MAX_HEIGHT);
        off = (k % 2) ? (k - 1) / 2 : k / 2;
        rlim = h + k - 1 - 2 * off;
        clim = w + k - 1 - 2 * off;
        if (px.start_of_frame)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        pix_store[(r % MAX_KERNEL) * MAX_WIDTH + c] = px.pixel;
        if (r >= k - 1 && c >= k - 1 && r < rlim && c < clim)
        begin
            top = r - (k - 1);
            left = c - (k - 1);
            any = 0;
            mn = 0;
            mx = 0;
            ctr = 0;
            for (int i = 0; i < k; i++)
            begin
                for (int j = 0; j < k; j++)
                begin
                    v = pix_store[((top + i) % MAX_KERNEL) * MAX_WIDTH + left + j];
                    if (i == off && j == off)
                        ctr = v;
                    if (mask_bit[i][j])
                    begin
                        if (!any || v < mn) mn = v;
                        if (!any || v > mx) mx = v;
                        any = 1;
                    end
                end
            end
            res.center_row = POS_W'(r - (k - 1 - off));
            res.center_col = POS_W'(c - (k - 1 - off));
            if (mx == mn)
            begin
                res.stretched = '0;
                res.flat_window = 1'b1;
            end
            else
            begin
                quot = (longint'(ctr - mn) * 65535) / longint'(mx - mn);
                if (quot > 65535) quot = 65535;
                res.stretched = PIXEL_BITS'(quot);
                res.flat_window = 1'b0;
            end
            res.last_of_frame = (r == rlim - 1) && (c == clim - 1);
            stretch_queue.push_back(res);
        end
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            k_reg = 4'd3;
            shape_reg = 2'd0;
            width_reg = 11'd640;
            height_reg = 11'd480;
            row_pos = 0;
            col_pos = 0;
            stretch_queue.delete();
            errors = 0;
            results = 0;
            flats = 0;
            rebuild_mask();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KERNEL_SIZE:  k_reg = cfg_data[3:0];
                    REG_MASK_SHAPE:   shape_reg = cfg_data[1:0];
                    REG_IMAGE_WIDTH:  width_reg = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                endcase
                rebuild_mask();
            end
            if (in_valid && !in_stall)
                predict_pixel(in_data);
            if (out_valid && !out_stall)
            begin
                if (stretch_queue.size() == 0)
                begin
                    $error("unexpected result row=%0d col=%0d", out_data.center_row,
                           out_data.center_col);
                    errors++;
                end
                else
                begin
                    want = stretch_queue.pop_front();
                    results++;
                    if (want.flat_window) flats++;
                    if (out_data.center_row !== want.center_row)
                    begin
                        $error("center_row: expected %0d, got %0d", want.center_row,
                               out_data.center_row);
                        errors++;
                    end
                    if (out_data.center_col !== want.center_col)
                    begin
                        $error("center_col: expected %0d, got %0d", want.center_col,
                               out_data.center_col);
                        errors++;
                    end
                    if (out_data.stretched !== want.stretched)
                    begin
                        $error("stretched: expected %0d, got %0d", want.stretched,
                               out_data.stretched);
                        errors++;
                    end
                    if (out_data.flat_window !== want.flat_window)
                    begin
                        $error("flat_window: expected %0d, got %0d", want.flat_window,
                               out_data.flat_window);
                        errors++;
                    end
                    if (out_data.last_of_frame !== want.last_of_frame)
                    begin
                        $error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
                               out_data.last_of_frame);
                        errors++;
                    end
                end
            end
        end
        pending = stretch_queue.size();
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

// Stimulus and verdict for the contrast stretch core. The checker beside the
// block does all prediction and comparison; this module only feeds pixels,
// writes registers between phases and applies back pressure.
module tb;
    import lmcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The full square and the spare shape code have no names in the package.
    localparam logic [1:0] SHAPE_SQUARE = 2'd0;
    localparam logic [1:0] SHAPE_RESERVED = 2'd3;
    // Longest legal silence on the channels: the back end's work on one result,
    // plus long output stalls and the settle time before a register write.
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 150;
    // Stall percentage of the phases that hold results back for long stretches.
    localparam int HEAVY_STALL_PCT = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic in_valid = 1'b0;
    in_t in_data = '0;
    logic in_stall;
    logic out_valid;
    out_t out_data;
    logic out_stall = 1'b0;

    int errors;
    int pending;
    int results;
    int flats;
    int sent;
    int phases;
    int idle_cycles;
    // Percentage of cycles the result side stalls, and whether the sender
    // inserts gaps at all; both change per phase.
    int stall_pct;
    bit sender_gaps;

    local_minmax_contrast_stretch_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_data(in_data),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_data(out_data),
        .out_stall(out_stall)
    );

    lmcs_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_data(in_data),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_data(out_data),
        .out_stall(out_stall),
        .errors(errors),
        .pending(pending),
        .results(results),
        .flats(flats)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The result side stalls at random; in the heavy phases a stall tends to
    // hold, so a result sits on the output for a while.
    always @(posedge clk)
    begin
        if ($urandom_range(999) < 4)
            out_stall <= 1'b1;
        else if (out_stall && $urandom_range(99) < 90 && stall_pct == HEAVY_STALL_PCT)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // The watchdog ends a run in which no request moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
            $display("** local_minmax_contrast_stretch_core: FAILED **");
            $finish;
        end
    end

    // Mostly no gap, some short gaps, a few long ones; none without sender_gaps.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (!sender_gaps || roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offers one pixel and holds it until the block takes it. Valid is only
    // lowered when a gap follows, so it is never lowered and raised in one step.
    task automatic send_pixel(input logic [15:0] value, input logic sof);
        int gap;
        in_valid <= 1'b1;
        in_data <= '{pixel: value, start_of_frame: sof};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits for every predicted result, then lets the back end finish any
    // pixel that produces nothing before the registers change.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int k, input int shape, input int w, input int h);
        cfg_we <= 1'b1;
        cfg_index <= REG_KERNEL_SIZE;
        cfg_data <= 11'(k);
        @(posedge clk);
        cfg_index <= REG_MASK_SHAPE;
        cfg_data <= 11'(shape);
        @(posedge clk);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= 11'(w);
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= 11'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        phases++;
    endtask

    // Content styles: fully random, a narrow band that often gives flat
    // windows, the two extremes, and a constant.
    function automatic logic [15:0] pick_pixel(int style, logic [15:0] base);
        case (style)
            0: return 16'($urandom);
            1: return base + 16'($urandom_range(1));
            2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return base;
        endcase
    endfunction

    // Sends whole frames with random content; some frames restart early and
    // some follow on without a start mark so the position wraps by itself.
    task automatic send_frames(input int w, input int h, input int count);
        int style;
        int cut;
        logic [15:0] base;
        bit sof_first;
        for (int f = 0; f < count; f++)
        begin
            style = $urandom_range(3);
            base = 16'($urandom);
            sof_first = (f == 0) || ($urandom_range(9) != 0);
            cut = ($urandom_range(9) == 0) ? $urandom_range(w * h - 1, 1) : w * h;
            for (int p = 0; p < cut; p++)
                send_pixel(pick_pixel(style, base), (p == 0) && sof_first);
        end
    endtask

    initial
    begin
        int k;
        int shape;
        int w;
        int h;
        int frames;
        sent = 0;
        phases = 0;
        idle_cycles = 0;
        stall_pct = 0;
        sender_gaps = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 4x4 frame of extremes, then a flat frame that stops after
        // nine of its sixteen pixels.
        configure(3, SHAPE_SQUARE, 4, 4);
        for (int p = 0; p < 16; p++)
            send_pixel((p % 3 == 0) ? 16'hFFFF : 16'h0000, p == 0);
        for (int p = 0; p < 9; p++)
            send_pixel(16'h8000, p == 0);
        drain();

        // Saturating register values and the largest frame sizes, sending only the
        // first part of each large frame so the run stays short.
        configure(15, SHAPE_RESERVED, 10, 10);
        send_frames(10, 10, 1);
        drain();
        configure(0, SHAPE_CIRCLE, 2047, 0);
        for (int p = 0; p < 1024 + 4; p++)
            send_pixel(16'($urandom), p == 0);
        drain();
        configure(1, SHAPE_WIDE_CIRCLE, 1, 1024);
        for (int p = 0; p < 60; p++)
            send_pixel(16'($urandom), p == 0);
        drain();
        configure(9, SHAPE_WIDE_CIRCLE, 24, 11);
        stall_pct = 30;
        for (int p = 0; p < 24 * 11; p++)
            send_pixel(16'($urandom_range(15)), p == 0);
        drain();

        // Random phases: random window, mask and frame size, mostly small
        // frames so windows reach full interior coverage quickly.
        while (sent < 1850)
        begin
            k = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(9, 2);
            shape = $urandom_range(3);
            w = ($urandom_range(14) == 0) ? $urandom_range(1) : $urandom_range(14, 2);
            h = ($urandom_range(14) == 0) ? $urandom_range(1) : $urandom_range(14, 2);
            stall_pct = ($urandom_range(3) == 0) ? 0
                      : (($urandom_range(3) == 0) ? HEAVY_STALL_PCT : 35);
            sender_gaps = $urandom_range(3) != 0;
            configure(k, shape, w, h);
            w = (w < 2) ? 2 : w;
            h = (h < 2) ? 2 : h;
            frames = 1 + 120 / (w * h);
            send_frames(w, h, frames);
            drain();
        end

        $display("Sent %0d pixels over %0d register settings; %0d results checked, %0d flat.",
                 sent, phases, results, flats);
        if (errors == 0)
            $display("** local_minmax_contrast_stretch_core: PASSED **");
        else
            $display("** local_minmax_contrast_stretch_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
